>>> sv/psp_pkg.sv
// Shared types and constants for the polyline symbol placement block.
package psp_pkg;

  localparam int unsigned CFG_W         = 10;
  localparam int unsigned COORD_W       = 16;
  localparam logic [CFG_W-1:0] MIN_SPACING   = 10'd2;
  localparam logic [CFG_W-1:0] SPACING_RESET = 10'd50;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      first_vertex;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] symbol_x;
    logic signed [COORD_W-1:0] symbol_y;
    logic                      last_of_run;
    logic                      truncated;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SX,
    ST_SY,
    ST_SS,
    ST_SW,
    ST_DEC,
    ST_TM,
    ST_TL,
    ST_TW,
    ST_M0,
    ST_L0,
    ST_W0,
    ST_MA,
    ST_LA,
    ST_WA,
    ST_EMIT
  } state_t;

endpackage

>>> sv/psp_sqrt.sv
// Bit-serial square root, two radicand bits per cycle, fixed-point result.
module psp_sqrt import psp_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [33:0]                   sum,
  output logic [17+FRACTION_BITS-1:0]   root,
  output logic                          done
);

  localparam int unsigned LW = 17 + FRACTION_BITS;
  localparam int unsigned CW = $clog2(LW + 1);

  logic [2*LW-1:0] rad;
  logic [LW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [LW+1:0]   rem_sh;
  logic [LW+1:0]   trial;
  logic            ge;

  always_comb begin
    rem_sh = {rem[LW-1:0], rad[2*LW-1 -: 2]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= {sum, {(2*FRACTION_BITS){1'b0}}};
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(LW);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[LW-2:0], ge};
        rad  <= rad << 2;
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/psp_div.sv
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
module psp_div import psp_pkg::*; #(
  parameter int unsigned NW = 38,
  parameter int unsigned VW = 26,
  parameter int unsigned QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [VW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [VW-1:0] rmd,
  output logic          done
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rs;
  logic          ge;

  always_comb begin
    rs = {rmd, num_sh[NW-1]};
    ge = rs >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_sh <= num;
        den_r  <= den;
        rmd    <= '0;
        quo    <= '0;
        cnt    <= CW'(NW);
        busy   <= 1'b1;
      end else if (busy) begin
        rmd    <= ge ? VW'(rs - {1'b0, den_r}) : rs[VW-1:0];
        quo    <= {quo[QW-2:0], ge};
        num_sh <= num_sh << 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/polyline_symbol_placement.sv
// Top level: sequencer, shared multiplier and stepping of symbol positions.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------
//  in      | in_valid / in_stall   | in_data  (in_t)
//  out     | out_valid / out_stall | out_data (out_t)
//  cfg     | cfg_valid / cfg_ready | cfg_data (spacing)
//
// A line-start vertex is taken without leaving the idle state. After acceptance
// a segment vertex forms the squares, sums them, takes the root and decides;
// when a symbol falls on it, five divisions follow on the shared divider, then
// one symbol per cycle while out_stall is low. Rst is synchronous and clears
// the line and the spacing register to 50. The output register lets the next
// vertex be taken while the last symbol still waits.
module polyline_symbol_placement import psp_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS_PER_SEGMENT = 64,
  parameter int unsigned FRACTION_BITS           = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned LW  = 17 + F;
  localparam int unsigned SFW = 10 + F;
  localparam int unsigned MBW = (SFW + 1 > 18) ? SFW + 1 : 18;
  localparam int unsigned PW  = 18 + MBW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned VW  = LW + 1;
  localparam int unsigned NCW = $clog2(MAX_SYMBOLS_PER_SEGMENT + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]        spacing;
  logic [CFG_W-1:0]        s_clamp;
  logic [SFW-1:0]          sf;
  logic signed [15:0]      prev_x, prev_y, vx, vy;
  logic signed [16:0]      dx, dy, delta;
  logic [SFW-1:0]          run_dist, dnew, cur, still;
  logic                    started;
  logic [33:0]             sum;
  logic [LW-1:0]           len;
  logic [VW-1:0]           den2;
  logic [LW:0]             rem;
  logic                    trunc;
  logic                    axis;
  logic [NCW-1:0]          n;

  logic signed [17:0]      mul_a;
  logic signed [MBW-1:0]   mul_b;
  logic signed [PW-1:0]    prod;

  logic                    sq_start, sq_done;
  logic [LW-1:0]           sq_root;
  logic                    dv_start, dv_done;
  logic [NW-1:0]           dv_num;
  logic [VW-1:0]           dv_den;
  logic [15:0]             dv_q;
  logic [VW-1:0]           dv_r;

  logic signed [NW:0]      nsig;
  logic                    nneg;
  logic [15:0]             fq;
  logic [VW-1:0]           fr;

  logic [15:0]             qx, qy, qax, qay;
  logic [VW-1:0]           rx, ry, rax, ray;
  logic [VW:0]             rsx, rsy;
  logic                    cx, cy;
  logic                    last;
  logic                    slot_free;
  logic                    in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    s_clamp = (spacing < MIN_SPACING) ? MIN_SPACING : spacing;
    sf      = {s_clamp, {F{1'b0}}};
    cur     = (run_dist > sf) ? sf : run_dist;
    still   = sf - cur;
    den2    = {len, 1'b0};
    delta   = axis ? dy : dx;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = {delta[16], delta};
    mul_b = MBW'($signed({1'b0, still}));
    case (state)
      ST_SX: begin
        mul_a = {dx[16], dx};
        mul_b = MBW'(dx);
      end
      ST_SY: begin
        mul_a = {dy[16], dy};
        mul_b = MBW'(dy);
      end
      ST_TM: begin
        mul_a = 18'(MAX_SYMBOLS_PER_SEGMENT);
        mul_b = MBW'($signed({1'b0, sf}));
      end
      ST_MA: begin
        mul_b = MBW'($signed({1'b0, sf}));
      end
      default: ;
    endcase
  end

  // divider operands; numerators go in as magnitudes, floor fixed afterwards
  always_comb begin
    nsig = (NW+1)'(prod) <<< 1;
    if (state == ST_L0) begin
      nsig = nsig + (NW+1)'($signed({1'b0, len}));
    end
    nneg     = nsig[NW];
    dv_start = (state == ST_TL) || (state == ST_L0) || (state == ST_LA);
    if (state == ST_TL) begin
      dv_num = NW'(rem) - NW'(1);
      dv_den = VW'(sf);
    end else begin
      dv_num = nneg ? NW'(-nsig) : NW'(nsig);
      dv_den = den2;
    end
    sq_start = (state == ST_SS);
  end

  // floor correction of the divider result
  logic neg_r;
  always_comb begin
    fq = dv_q;
    fr = dv_r;
    if (neg_r) begin
      if (dv_r != '0) begin
        fq = ~dv_q;
        fr = den2 - dv_r;
      end else begin
        fq = -dv_q;
      end
    end
  end

  always_comb begin
    rsx  = {1'b0, rx} + {1'b0, rax};
    rsy  = {1'b0, ry} + {1'b0, ray};
    cx   = rsx >= {1'b0, den2};
    cy   = rsy >= {1'b0, den2};
    last = (rem <= (LW+1)'(sf)) || (n == NCW'(MAX_SYMBOLS_PER_SEGMENT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && !in_data.first_vertex && started) begin
          state_next = ST_SX;
        end
      end
      ST_SX:  state_next = ST_SY;
      ST_SY:  state_next = ST_SS;
      ST_SS:  state_next = ST_SW;
      ST_SW: begin
        if (sq_done) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC: state_next = ((LW+1)'(len) <= (LW+1)'(still)) ? ST_IDLE : ST_TM;
      ST_TM:  state_next = ST_TL;
      ST_TL:  state_next = ST_TW;
      ST_TW: begin
        if (dv_done) begin
          state_next = ST_M0;
        end
      end
      ST_M0:  state_next = ST_L0;
      ST_L0:  state_next = ST_W0;
      ST_W0: begin
        if (dv_done) begin
          state_next = ST_MA;
        end
      end
      ST_MA:  state_next = ST_LA;
      ST_LA:  state_next = ST_WA;
      ST_WA: begin
        if (dv_done) begin
          state_next = axis ? ST_EMIT : ST_M0;
        end
      end
      ST_EMIT: begin
        if (slot_free && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      spacing   <= SPACING_RESET;
      started   <= 1'b0;
      run_dist  <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spacing <= cfg_data;
      end
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            vx <= in_data.vertex_x;
            vy <= in_data.vertex_y;
            dx <= 17'(in_data.vertex_x) - 17'(prev_x);
            dy <= 17'(in_data.vertex_y) - 17'(prev_y);
            if (in_data.first_vertex || !started) begin
              prev_x   <= in_data.vertex_x;
              prev_y   <= in_data.vertex_y;
              run_dist <= sf >> 1;
              started  <= 1'b1;
            end
          end
        end
        ST_SY: sum <= prod[33:0];
        ST_SS: sum <= sum + prod[33:0];
        ST_SW: begin
          if (sq_done) begin
            len <= sq_root;
          end
        end
        ST_DEC: begin
          rem <= (LW+1)'(cur) + (LW+1)'(len) - (LW+1)'(sf);
          if ((LW+1)'(len) <= (LW+1)'(still)) begin
            run_dist <= cur + SFW'(len);
            prev_x   <= vx;
            prev_y   <= vy;
          end
        end
        ST_TL: begin
          trunc <= PW'(rem) > prod;
          neg_r <= 1'b0;
        end
        ST_TW: begin
          if (dv_done) begin
            dnew <= SFW'(dv_r) + 1'b1;
            axis <= 1'b0;
          end
        end
        ST_L0, ST_LA: neg_r <= nneg;
        ST_W0: begin
          if (dv_done) begin
            if (axis) begin
              qy <= fq;
              ry <= fr;
            end else begin
              qx <= fq;
              rx <= fr;
            end
          end
        end
        ST_WA: begin
          if (dv_done) begin
            if (axis) begin
              qay <= fq;
              ray <= fr;
            end else begin
              qax <= fq;
              rax <= fr;
            end
            axis <= 1'b1;
            n    <= '0;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data.symbol_x    <= prev_x + qx;
            out_data.symbol_y    <= prev_y + qy;
            out_data.last_of_run <= last;
            out_data.truncated   <= trunc;
            n   <= n + 1'b1;
            rem <= rem - (LW+1)'(sf);
            qx  <= qx + qax + 16'(cx);
            qy  <= qy + qay + 16'(cy);
            rx  <= cx ? VW'(rsx - {1'b0, den2}) : rsx[VW-1:0];
            ry  <= cy ? VW'(rsy - {1'b0, den2}) : rsy[VW-1:0];
            if (last) begin
              prev_x   <= vx;
              prev_y   <= vy;
              run_dist <= dnew;
            end
          end
        end
        default: ;
      endcase
    end
  end

  psp_sqrt #(
    .FRACTION_BITS(F)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .sum   (sum + prod[33:0]),
    .root  (sq_root),
    .done  (sq_done)
  );

  psp_div #(
    .NW(NW),
    .VW(VW),
    .QW(16)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .quo   (dv_q),
    .rmd   (dv_r),
    .done  (dv_done)
  );

endmodule

>>> tb/tb_polyline_symbol_placement.sv
// Testbench for the polyline symbol placement block: random driver, predictor and checker.
module tb_polyline_symbol_placement;
  import psp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SYM = 64;
  localparam int unsigned FRAC    = 8;
  localparam longint LIMIT        = 20000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  polyline_symbol_placement i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0]   spacing_q = SPACING_RESET;
  logic signed [15:0] prev_x = '0, prev_y = '0;
  longint unsigned    dist_q = 0;
  bit                 started = 1'b0;

  in_t    vertex_q[$];
  out_t   symbols_due[$];
  int     errors = 0;
  bit     hold_off = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned root_fixed(longint unsigned sum);
    longint unsigned root, remd, trial, b;
    root = 0;
    remd = 0;
    for (int i = 16 + FRAC; i >= 0; i--) begin
      b = (i >= FRAC) ? ((sum >> (2 * (i - FRAC))) & 3) : 0;
      remd = (remd << 2) | b;
      trial = (root << 2) | 1;
      if (remd >= trial) begin
        remd -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint round_step(longint delta, longint unsigned t, longint unsigned len);
    longint den, num;
    den = 2 * longint'(len);
    num = 2 * delta * longint'(t) + longint'(len);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  task automatic place_symbols(in_t v);
    longint unsigned s, sf, len, cur, still, t, rest;
    longint dx, dy;
    out_t   r;
    out_t   run[$];
    bit     trunc;
    s = (spacing_q < MIN_SPACING) ? MIN_SPACING : spacing_q;
    sf = s << FRAC;
    trunc = 1'b0;
    if (v.first_vertex || !started) begin
      prev_x = v.vertex_x;
      prev_y = v.vertex_y;
      dist_q = sf >> 1;
      started = 1'b1;
      return;
    end
    dx = longint'(v.vertex_x) - longint'(prev_x);
    dy = longint'(v.vertex_y) - longint'(prev_y);
    len = root_fixed(longint'(dx * dx + dy * dy));
    cur = (dist_q > sf) ? sf : dist_q;
    still = sf - cur;
    if (len <= still) begin
      dist_q = cur + len;
    end else begin
      t = still;
      rest = cur + len - sf;
      forever begin
        r.symbol_x = 16'(longint'(prev_x) + round_step(dx, t, len));
        r.symbol_y = 16'(longint'(prev_y) + round_step(dy, t, len));
        r.last_of_run = 1'b0;
        r.truncated = 1'b0;
        run.push_back(r);
        if (rest <= sf) break;
        if (run.size() >= MAX_SYM) begin
          trunc = 1'b1;
          rest = ((rest - 1) % sf) + 1;
          break;
        end
        rest -= sf;
        t += sf;
      end
      run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) begin
        run[k].truncated = trunc;
        symbols_due.push_back(run[k]);
      end
      dist_q = rest;
    end
    prev_x = v.vertex_x;
    prev_y = v.vertex_y;
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        place_symbols(in_data);
        void'(vertex_q.pop_front());
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap > 0 && !(in_valid && in_stall)) begin
        gap--;
        in_valid <= 1'b0;
      end else if (!(in_valid && in_stall)) begin
        if (vertex_q.size() > (in_valid && !in_stall ? 0 : 0) && vertex_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= vertex_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          $display("%0t: unexpected symbol, actual %p", $realtime, out_data);
          errors++;
        end else begin
          if (out_data.symbol_x !== symbols_due[0].symbol_x)
            $display("%0t: symbol_x expected %0d actual %0d", $realtime,
                     symbols_due[0].symbol_x, out_data.symbol_x);
          if (out_data.symbol_y !== symbols_due[0].symbol_y)
            $display("%0t: symbol_y expected %0d actual %0d", $realtime,
                     symbols_due[0].symbol_y, out_data.symbol_y);
          if (out_data.last_of_run !== symbols_due[0].last_of_run)
            $display("%0t: last_of_run expected %0b actual %0b", $realtime,
                     symbols_due[0].last_of_run, out_data.last_of_run);
          if (out_data.truncated !== symbols_due[0].truncated)
            $display("%0t: truncated expected %0b actual %0b", $realtime,
                     symbols_due[0].truncated, out_data.truncated);
          if (out_data !== symbols_due[0]) errors++;
          void'(symbols_due.pop_front());
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                     : $urandom_range(1, 3);
      end
    end
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_t mk_vertex(int x, int y, bit first);
    in_t v;
    v.vertex_x = 16'(x);
    v.vertex_y = 16'(y);
    v.first_vertex = first;
    return v;
  endfunction

  task automatic wait_idle();
    while (vertex_q.size() > 0 || in_valid || symbols_due.size() > 0) @(posedge clk);
    // a segment with no symbols may still be in the square root
    repeat (400) @(posedge clk);
  endtask

  task automatic write_spacing(logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    spacing_q = val;
    cfg_valid <= 1'b0;
  endtask

  // random polyline: a start vertex then a walk of short steps, with occasional jumps and line restarts
  task automatic random_line(int steps, int reach);
    int x, y;
    x = $urandom_range(0, 60000) - 30000;
    y = $urandom_range(0, 60000) - 30000;
    vertex_q.push_back(mk_vertex(x, y, 1'b1));
    repeat (steps) begin
      if ($urandom_range(0, 19) == 0) begin
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
      end else begin
        x = x + $urandom_range(0, 2 * reach) - reach;
        y = y + $urandom_range(0, 2 * reach) - reach;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
      end
      vertex_q.push_back(mk_vertex(x, y, $urandom_range(0, 30) == 0));
    end
  endtask

  initial begin
    int settings[6] = '{50, 0, 1023, 2, 7, 300};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: line not begun, extremes, zero segment, truncation
    vertex_q.push_back(mk_vertex(10, 10, 1'b0));
    vertex_q.push_back(mk_vertex(10, 10, 1'b0));
    vertex_q.push_back(mk_vertex(200, -30, 1'b0));
    vertex_q.push_back(mk_vertex(-32768, -32768, 1'b1));
    vertex_q.push_back(mk_vertex(32767, 32767, 1'b0));
    vertex_q.push_back(mk_vertex(-32768, 32767, 1'b0));
    vertex_q.push_back(mk_vertex(0, 0, 1'b1));
    vertex_q.push_back(mk_vertex(-7, 3, 1'b0));
    vertex_q.push_back(mk_vertex(-25, 0, 1'b0));
    wait_idle();
    write_spacing(10'd0);
    vertex_q.push_back(mk_vertex(0, 0, 1'b1));
    vertex_q.push_back(mk_vertex(5, 1, 1'b0));
    vertex_q.push_back(mk_vertex(-200, 90, 1'b0));
    wait_idle();
    write_spacing(10'd1023);
    vertex_q.push_back(mk_vertex(0, 0, 1'b1));
    vertex_q.push_back(mk_vertex(900, 0, 1'b0));
    wait_idle();
    // lowered spacing mid-line clamps the running distance
    write_spacing(10'd3);
    vertex_q.push_back(mk_vertex(901, 0, 1'b0));
    vertex_q.push_back(mk_vertex(901, -10, 1'b0));
    wait_idle();
    // long receiver hold-off while the sender keeps offering
    write_spacing(10'd5);
    hold_off = 1'b1;
    random_line(20, 40);
    repeat (1500) @(posedge clk);
    hold_off = 1'b0;
    wait_idle();
    foreach (settings[i]) begin
      write_spacing(settings[i][CFG_W-1:0]);
      repeat (3) random_line(24, (i % 2) ? 60 : 400);
      wait_idle();
    end
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
sv/psp_pkg.sv
sv/psp_sqrt.sv
sv/psp_div.sv
sv/polyline_symbol_placement.sv
tb/tb_polyline_symbol_placement.sv
